FILE: src/lfio_pkg.sv
// Shared constants, types and control structs for the linear fade block.
// No dependencies; every other file in src uses this package.
package lfio_pkg;

    localparam int CNT_W     = 24;
    localparam int SMP_W     = 32;
    localparam int MUL_STEPS = (CNT_W + 1) / 2;
    localparam int MUL_BITS  = 2 * MUL_STEPS;
    localparam int PROD_W    = SMP_W + CNT_W;
    localparam int DIV_STEPS = SMP_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int IDX_W     = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_CLIP_LEN = 2'd0,
        CFG_FADE_IN  = 2'd1,
        CFG_FADE_OUT = 2'd2
    } lfio_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SEL,
        ST_DIV,
        ST_DONE
    } lfio_state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } lfio_ctrl_t;

endpackage

FILE: src/linear_fade_in_out.sv
// A sample is accepted in ST_IDLE and passes ST_MUL, ST_SEL, ST_DIV and ST_DONE; the
// next is taken only after ST_DONE, which stalls while an unread result is held.
// Pace: radix-4 serial multiplier lanes and the two-bit-per-cycle serial divider.
// A finished result waits in the output register while the next sample is taken.
// Reset (aresetn low, synchronous) clears the state, config, position and handshakes only.
// Top level; depends on lfio_pkg, lfio_mul_lane and lfio_div.
module linear_fade_in_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfio_pkg::IDX_W-1:0]        cfg_index,
    input  logic [lfio_pkg::CNT_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lfio_pkg::SMP_W-1:0]        s_tdata,   // [31:0] sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lfio_pkg::SMP_W-1:0]        m_tdata,   // [31:0] sample_out
    output logic                              m_tlast
);

    lfio_pkg::lfio_state_t       state_reg, state_next;
    logic [lfio_pkg::STEP_W-1:0] cnt_reg;

    logic [lfio_pkg::CNT_W-1:0]  clip_len_reg;
    logic [lfio_pkg::CNT_W-1:0]  fade_in_reg;
    logic [lfio_pkg::CNT_W-1:0]  fade_out_reg;
    logic [lfio_pkg::CNT_W-1:0]  pos_reg;

    logic                        neg_reg;
    logic                        last_reg;
    logic                        b_act_reg;
    logic [lfio_pkg::CNT_W-1:0]  da_reg;
    logic [lfio_pkg::CNT_W-1:0]  db_reg;

    logic                        m_tvalid_reg;
    logic [lfio_pkg::SMP_W-1:0]  m_tdata_reg;
    logic                        m_tlast_reg;

    logic                        s_accept;
    logic                        out_load;
    lfio_pkg::lfio_ctrl_t        lane_ctrl;
    lfio_pkg::lfio_ctrl_t        div_ctrl;

    logic [lfio_pkg::SMP_W-1:0]  mag;
    logic [lfio_pkg::CNT_W-1:0]  fi;
    logic [lfio_pkg::CNT_W-1:0]  fo;
    logic                        in_clip;
    logic                        a_act;
    logic                        b_act;
    logic                        last_c;
    logic [lfio_pkg::CNT_W-1:0]  na;
    logic [lfio_pkg::CNT_W-1:0]  da;
    logic [lfio_pkg::CNT_W-1:0]  nb;
    logic [lfio_pkg::CNT_W:0]    pos_inc;

    logic [lfio_pkg::PROD_W-1:0] prod_a;
    logic [lfio_pkg::PROD_W-1:0] prod_b;
    logic [lfio_pkg::PROD_W-1:0] cross_a;
    logic [lfio_pkg::PROD_W-1:0] cross_b;
    logic                        sel_b;
    logic [lfio_pkg::PROD_W-1:0] sel_prod;
    logic [lfio_pkg::CNT_W-1:0]  sel_den;
    logic [lfio_pkg::SMP_W-1:0]  quotient;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    // gain selection for the sample at the current position
    always_comb begin
        mag     = s_tdata[lfio_pkg::SMP_W-1] ? (~s_tdata + 1'b1) : s_tdata;
        in_clip = (clip_len_reg != '0) && (pos_reg < clip_len_reg);
        fi      = (fade_in_reg  < clip_len_reg) ? fade_in_reg  : clip_len_reg;
        fo      = (fade_out_reg < clip_len_reg) ? fade_out_reg : clip_len_reg;
        a_act   = in_clip && (pos_reg < fi);
        b_act   = in_clip && (fo != '0) && (pos_reg >= (clip_len_reg - fo));
        na      = a_act ? pos_reg : lfio_pkg::CNT_W'(1);
        da      = a_act ? fi : lfio_pkg::CNT_W'(1);
        nb      = clip_len_reg - pos_reg;
        pos_inc = {1'b0, pos_reg} + 1'b1;
        last_c  = !in_clip || (pos_inc >= {1'b0, clip_len_reg});
    end

    lfio_mul_lane u_lane_a (
        .aclk      (aclk),
        .ctrl      (lane_ctrl),
        .mcand_in  (mag),
        .mplier_in (na),
        .product   (prod_a)
    );

    lfio_mul_lane u_lane_b (
        .aclk      (aclk),
        .ctrl      (lane_ctrl),
        .mcand_in  (mag),
        .mplier_in (nb),
        .product   (prod_b)
    );

    lfio_mul_lane u_cross_a (
        .aclk      (aclk),
        .ctrl      (lane_ctrl),
        .mcand_in  (lfio_pkg::SMP_W'(na)),
        .mplier_in (fo),
        .product   (cross_a)
    );

    lfio_mul_lane u_cross_b (
        .aclk      (aclk),
        .ctrl      (lane_ctrl),
        .mcand_in  (lfio_pkg::SMP_W'(nb)),
        .mplier_in (da),
        .product   (cross_b)
    );

    always_comb begin
        sel_b    = b_act_reg && (cross_b < cross_a);
        sel_prod = sel_b ? prod_b : prod_a;
        sel_den  = sel_b ? db_reg : da_reg;
    end

    lfio_div u_div (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .dividend (sel_prod),
        .divisor  (sel_den),
        .quotient (quotient)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfio_pkg::ST_IDLE: if (s_tvalid) state_next = lfio_pkg::ST_MUL;
            lfio_pkg::ST_MUL:  if (cnt_reg == '0) state_next = lfio_pkg::ST_SEL;
            lfio_pkg::ST_SEL:  state_next = lfio_pkg::ST_DIV;
            lfio_pkg::ST_DIV:  if (cnt_reg == '0) state_next = lfio_pkg::ST_DONE;
            lfio_pkg::ST_DONE: if (!m_tvalid_reg || m_tready) state_next = lfio_pkg::ST_IDLE;
            default:           state_next = lfio_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = (state_reg == lfio_pkg::ST_IDLE);
        lane_ctrl.load  = (state_reg == lfio_pkg::ST_IDLE) && s_tvalid;
        lane_ctrl.shift = (state_reg == lfio_pkg::ST_MUL);
        div_ctrl.load   = (state_reg == lfio_pkg::ST_SEL);
        div_ctrl.shift  = (state_reg == lfio_pkg::ST_DIV);
        out_load        = (state_reg == lfio_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfio_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            priority if (s_accept) begin
                cnt_reg <= lfio_pkg::STEP_W'(lfio_pkg::MUL_STEPS - 1);
            end else if (state_reg == lfio_pkg::ST_SEL) begin
                cnt_reg <= lfio_pkg::STEP_W'(lfio_pkg::DIV_STEPS - 1);
            end else if ((state_reg == lfio_pkg::ST_MUL || state_reg == lfio_pkg::ST_DIV)
                         && cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end else begin
                cnt_reg <= cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_len_reg <= '0;
            fade_in_reg  <= '0;
            fade_out_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lfio_pkg::CFG_CLIP_LEN: clip_len_reg <= cfg_data;
                lfio_pkg::CFG_FADE_IN:  fade_in_reg  <= cfg_data;
                lfio_pkg::CFG_FADE_OUT: fade_out_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // advance or wrap the clip position on every accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (s_accept) begin
            pos_reg <= last_c ? '0 : pos_inc[lfio_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            neg_reg   <= s_tdata[lfio_pkg::SMP_W-1];
            last_reg  <= last_c;
            b_act_reg <= b_act;
            da_reg    <= da;
            db_reg    <= fo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= neg_reg ? (~quotient + 1'b1) : quotient;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_wrap_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && last_c) |=> (pos_reg == '0))
        else $error("position did not wrap after last sample");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfio_pkg::ST_SEL) |-> (sel_den != '0))
        else $error("divider loaded with zero denominator");

    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfio_pkg::ST_MUL) |->
            (cnt_reg <= lfio_pkg::STEP_W'(lfio_pkg::MUL_STEPS - 1)))
        else $error("multiplier step count out of range");

    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == lfio_pkg::ST_DONE))
        else $error("output raised outside the done state");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfio_pkg::ST_DIV) |=>
            (state_reg == lfio_pkg::ST_DIV || state_reg == lfio_pkg::ST_DONE))
        else $error("divider sequence left early");

endmodule

FILE: src/lfio_mul_lane.sv
// Radix-4 serial multiplier lane: 32-bit multiplicand times CNT_W-bit multiplier.
// Depends on lfio_pkg.
module lfio_mul_lane (
    input  logic                          aclk,
    input  lfio_pkg::lfio_ctrl_t          ctrl,
    input  logic [lfio_pkg::SMP_W-1:0]    mcand_in,
    input  logic [lfio_pkg::CNT_W-1:0]    mplier_in,
    output logic [lfio_pkg::PROD_W-1:0]   product
);

    logic [lfio_pkg::SMP_W-1:0]                    mcand_reg;
    logic [lfio_pkg::SMP_W+lfio_pkg::MUL_BITS-1:0] p_reg;
    logic [lfio_pkg::SMP_W+lfio_pkg::MUL_BITS-1:0] p_next;
    logic [lfio_pkg::SMP_W+1:0]                    sum;

    always_comb begin
        sum = {2'b00, p_reg[lfio_pkg::SMP_W+lfio_pkg::MUL_BITS-1:lfio_pkg::MUL_BITS]}
            + (p_reg[0] ? {2'b00, mcand_reg} : '0)
            + (p_reg[1] ? {1'b0, mcand_reg, 1'b0} : '0);
        p_next = {sum, p_reg[lfio_pkg::MUL_BITS-1:2]};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            mcand_reg <= mcand_in;
            p_reg     <= {{lfio_pkg::SMP_W{1'b0}}, lfio_pkg::MUL_BITS'(mplier_in)};
        end else if (ctrl.shift) begin
            p_reg     <= p_next;
        end
    end

    assign product = p_reg[lfio_pkg::PROD_W-1:0];

endmodule

FILE: src/lfio_div.sv
// Serial restoring divider, two quotient bits per cycle while ctrl.shift is high; quotient fits 32 bits.
// Depends on lfio_pkg.
module lfio_div (
    input  logic                          aclk,
    input  lfio_pkg::lfio_ctrl_t          ctrl,
    input  logic [lfio_pkg::PROD_W-1:0]   dividend,
    input  logic [lfio_pkg::CNT_W-1:0]    divisor,
    output logic [lfio_pkg::SMP_W-1:0]    quotient
);

    logic [lfio_pkg::CNT_W-1:0] rem_reg;
    logic [lfio_pkg::CNT_W-1:0] rem_next;
    logic [lfio_pkg::CNT_W-1:0] rem_mid;
    logic [lfio_pkg::SMP_W-1:0] quo_reg;
    logic [lfio_pkg::SMP_W-1:0] quo_next;
    logic [lfio_pkg::SMP_W-1:0] quo_mid;
    logic [lfio_pkg::CNT_W-1:0] den_reg;
    logic [lfio_pkg::CNT_W:0]   r1;
    logic [lfio_pkg::CNT_W:0]   r2;
    logic [lfio_pkg::CNT_W:0]   d1;
    logic [lfio_pkg::CNT_W:0]   d2;
    logic                       ge1;
    logic                       ge2;

    always_comb begin
        r1       = {rem_reg, quo_reg[lfio_pkg::SMP_W-1]};
        ge1      = (r1 >= {1'b0, den_reg});
        d1       = ge1 ? (r1 - {1'b0, den_reg}) : r1;
        rem_mid  = d1[lfio_pkg::CNT_W-1:0];
        quo_mid  = {quo_reg[lfio_pkg::SMP_W-2:0], ge1};
        r2       = {rem_mid, quo_mid[lfio_pkg::SMP_W-1]};
        ge2      = (r2 >= {1'b0, den_reg});
        d2       = ge2 ? (r2 - {1'b0, den_reg}) : r2;
        rem_next = d2[lfio_pkg::CNT_W-1:0];
        quo_next = {quo_mid[lfio_pkg::SMP_W-2:0], ge2};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rem_reg <= dividend[lfio_pkg::PROD_W-1:lfio_pkg::SMP_W];
            quo_reg <= dividend[lfio_pkg::SMP_W-1:0];
            den_reg <= divisor;
        end else if (ctrl.shift) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule
